// File: sv/sal_pkg.sv
// Shared types and constants for the set-associative LRU tag store.
// No dependencies; imported by the interfaces and the top, front and back modules.
package sal_pkg;

    // Fixed field widths
    localparam int ADDR_W      = 64;
    localparam int OP_W        = 2;
    localparam int HITS_W      = 2;
    localparam int RES_CNT_W   = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 4;
    localparam int QUEUE_DEPTH = 2;

    // Access opcodes
    localparam logic [OP_W-1:0] OP_FETCH  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd2;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd3;

    // Register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS        = 2'd2;

    // Register reset values
    localparam logic [2:0] RST_SET_BITS    = 3'd4;
    localparam logic [4:0] RST_OFFSET_BITS = 5'd4;
    localparam logic [3:0] RST_WAYS        = 4'd1;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [4:0] offset_bits;
        logic [3:0] ways;
    } t_cfg;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EVAL,
        BK_WRITE
    } t_back_state;

endpackage

// File: sv/sal_if.sv
// Valid/ready channel interfaces: access requests in, lookup results out.
// Depends on sal_pkg for field widths.
interface sal_req_if import sal_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       opcode;
    logic [ADDR_W-1:0]     address;

    modport source (output valid, opcode, address, input ready);
    modport sink   (input valid, opcode, address, output ready);
endinterface

interface sal_res_if import sal_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [HITS_W-1:0]     hits_in_item;
    logic                  missed;
    logic                  evicted;
    logic [RES_CNT_W-1:0]  total_hits;
    logic [RES_CNT_W-1:0]  total_misses;
    logic [RES_CNT_W-1:0]  total_evictions;

    modport source (output valid, hits_in_item, missed, evicted, total_hits, total_misses,
                    total_evictions, input ready);
    modport sink   (input valid, hits_in_item, missed, evicted, total_hits, total_misses,
                    total_evictions, output ready);
endinterface

// File: sv/set_assoc_lru_cache_sim.sv
// Flow: an accepted load, store or modify is queued; the back end pops it, reads
// its set row, scans the ways, then writes the row back and loads the result
// register, waiting while an earlier result is unaccepted. An instruction fetch
// is accepted and gives no result. The back end finishes this sequence on the
// single set RAM before it pops the next request; the 2-entry queue absorbs bursts.
// Reset (sync, active low): registers to defaults, totals to zero, then a
// clearing pass over all 2**MAX_SET_BITS sets (64 by default) with input ready low.
module set_assoc_lru_cache_sim import sal_pkg::*; #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int AGE_BITS     = 32,
    parameter int COUNT_BITS   = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    sal_req_if.sink               i_req,
    sal_res_if.source             o_res
);
    localparam int SET_AW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ENTRY_W = 1 + ADDR_W + SET_AW;

    t_cfg               cfg;
    logic               clearing;
    logic               q_full, q_push, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_in, q_out;

    // Intake and classification
    sal_front #(
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (cfg),
        .i_req      (i_req),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    // Decoupling queue
    sal_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // Lookup and replacement
    sal_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .AGE_BITS     (AGE_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_out),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_res      (o_res)
    );
endmodule

// File: sv/sal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/sal_queue.sv
// Short FIFO between the classifying front end and the lookup back end.
// No dependencies.
module sal_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// File: sv/sal_front.sv
// Front end: APB configuration registers, request intake, address split.
// Depends on sal_pkg and sal_req_if; feeds sal_queue.
module sal_front import sal_pkg::*; #(
    parameter int MAX_SET_BITS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg,
    // request channel
    sal_req_if.sink               i_req,
    // queue side
    input  logic                  i_clearing,
    input  logic                  i_q_full,
    output logic                  o_push,
    output logic [1 + ADDR_W + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) - 1:0] o_entry
);
    localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    t_cfg              r_cfg;
    logic              cfg_wr;
    logic [3:0]        s_eff;
    logic [5:0]        tag_shift;
    logic [ADDR_W-1:0] addr_off;
    logic [ADDR_W-1:0] tag;
    logic [SET_AW-1:0] set_mask;
    logic [SET_AW-1:0] set_idx;
    logic              is_data;
    logic              accept;

    // Register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits    <= RST_SET_BITS;
            r_cfg.offset_bits <= RST_OFFSET_BITS;
            r_cfg.ways        <= RST_WAYS;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SET_BITS:    r_cfg.set_bits    <= pwdata[2:0];
                REG_OFFSET_BITS: r_cfg.offset_bits <= pwdata[4:0];
                REG_WAYS:        r_cfg.ways        <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_SET_BITS:    prdata = CFG_DATA_W'(r_cfg.set_bits);
            REG_OFFSET_BITS: prdata = CFG_DATA_W'(r_cfg.offset_bits);
            REG_WAYS:        prdata = CFG_DATA_W'(r_cfg.ways);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

    // Address split: offset | set | tag
    always_comb begin
        s_eff = ({1'b0, r_cfg.set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                             : {1'b0, r_cfg.set_bits};
        tag_shift = 6'(s_eff) + 6'(r_cfg.offset_bits);
        tag       = i_req.address >> tag_shift;
        addr_off  = i_req.address >> r_cfg.offset_bits;
        for (int i = 0; i < SET_AW; i++) begin
            set_mask[i] = (4'(i) < s_eff);
        end
        set_idx = addr_off[SET_AW-1:0] & set_mask;
    end

    // Classify: fetches are taken and dropped
    always_comb begin
        case (i_req.opcode) inside
            OP_LOAD, OP_STORE, OP_MODIFY: is_data = 1'b1;
            default:                      is_data = 1'b0;
        endcase
    end

    assign i_req.ready = !i_clearing && !i_q_full;
    assign accept      = i_req.valid && i_req.ready;
    assign o_push      = accept && is_data;
    assign o_entry     = {(i_req.opcode == OP_MODIFY), tag, set_idx};
endmodule

// File: sv/sal_back.sv
// Back end: set RAM, way lookup, LRU fill/evict, saturating totals, result register.
// Depends on sal_pkg, sal_res_if and sal_ram.
module sal_back import sal_pkg::*; #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int AGE_BITS     = 32,
    parameter int COUNT_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  logic [1 + ADDR_W + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) - 1:0] i_q_entry,
    output logic        o_q_pop,
    output logic        o_clearing,
    sal_res_if.source   o_res
);
    localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int ENTRY_W  = 1 + ADDR_W + SET_AW;
    localparam int WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W    = 1 + ADDR_W + AGE_BITS;
    localparam int ROW_W    = MAX_WAYS * WAY_W;
    localparam int CMP_W    = ($clog2(MAX_WAYS + 1) > 4) ? $clog2(MAX_WAYS + 1) : 4;
    localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(NUM_SETS - 1);

    t_back_state        r_state, n_state;
    logic [SET_AW-1:0]  r_clr_set;
    logic               r_mod;
    logic [ADDR_W-1:0]  r_tag;
    logic [SET_AW-1:0]  r_set;
    logic               r_hit, r_emp;
    logic [WAY_IW-1:0]  r_hit_way, r_emp_way, r_lru_way;
    logic [AGE_BITS-1:0] r_max_age;
    logic [COUNT_BITS-1:0] r_hit_cnt, r_miss_cnt, r_evict_cnt;
    logic               r_out_valid;
    logic [HITS_W-1:0]  r_out_hits;
    logic               r_out_missed, r_out_evicted;

    logic               ram_we, ram_re;
    logic [SET_AW-1:0]  ram_waddr;
    logic [ROW_W-1:0]   ram_wdata, ram_rdata, new_row;
    logic               do_eval, do_commit, slot_free;

    logic [CMP_W-1:0]   ways_raw, ways_eff;
    logic               e_hit, e_emp;
    logic [WAY_IW-1:0]  e_hit_way, e_emp_way, e_lru_way;
    logic [AGE_BITS-1:0] e_max_age, e_min_age, e_age;
    logic [ADDR_W-1:0]  e_tag;
    logic               e_valid;

    logic [WAY_IW-1:0]  victim;
    logic [AGE_BITS:0]  age_sum;
    logic [AGE_BITS-1:0] new_age;
    logic [HITS_W-1:0]  item_hits;
    logic               item_miss, item_evict;
    logic [COUNT_BITS:0] hit_sum, miss_sum, evict_sum;

    // Set RAM: one row per set, each way {valid, tag, age}
    sal_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_q_entry[SET_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign slot_free  = !r_out_valid || o_res.ready;
    assign o_clearing = (r_state == BK_CLEAR);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: if (r_clr_set == LAST_SET) n_state = BK_IDLE;
            BK_IDLE:  if (i_q_valid) n_state = BK_EVAL;
            BK_EVAL:  n_state = BK_WRITE;
            BK_WRITE: if (slot_free) n_state = BK_IDLE;
            default:  n_state = BK_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_set;
        ram_wdata = new_row;
        o_q_pop   = 1'b0;
        do_eval   = 1'b0;
        do_commit = 1'b0;
        unique case (r_state)
            BK_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_set;
                ram_wdata = '0;
            end
            BK_IDLE: begin
                ram_re  = i_q_valid;
                o_q_pop = i_q_valid;
            end
            BK_EVAL: begin
                do_eval = 1'b1;
            end
            BK_WRITE: begin
                ram_we    = slot_free;
                do_commit = slot_free;
            end
            default: ;
        endcase
    end

    // Way scan over the row just read
    always_comb begin
        ways_raw = CMP_W'(i_cfg.ways);
        if (ways_raw == '0) begin
            ways_eff = CMP_W'(1);
        end else if (ways_raw > CMP_W'(MAX_WAYS)) begin
            ways_eff = CMP_W'(MAX_WAYS);
        end else begin
            ways_eff = ways_raw;
        end
        e_hit     = 1'b0;
        e_emp     = 1'b0;
        e_hit_way = '0;
        e_emp_way = '0;
        e_lru_way = '0;
        e_max_age = '0;
        e_min_age = '0;
        e_age     = '0;
        e_tag     = '0;
        e_valid   = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            e_age   = ram_rdata[w*WAY_W +: AGE_BITS];
            e_tag   = ram_rdata[w*WAY_W + AGE_BITS +: ADDR_W];
            e_valid = ram_rdata[w*WAY_W + AGE_BITS + ADDR_W];
            if (CMP_W'(w) < ways_eff) begin
                if (e_age > e_max_age) e_max_age = e_age;
                // strict less keeps the lowest way on ties
                if (w == 0 || e_age < e_min_age) begin
                    e_min_age = e_age;
                    e_lru_way = WAY_IW'(w);
                end
                if (e_valid) begin
                    if (!e_hit && e_tag == r_tag) begin
                        e_hit     = 1'b1;
                        e_hit_way = WAY_IW'(w);
                    end
                end else if (!e_emp) begin
                    e_emp     = 1'b1;
                    e_emp_way = WAY_IW'(w);
                end
            end
        end
    end

    // Row update; a modify's second lookup always hits the line just touched,
    // so it lands as max age plus two.
    always_comb begin
        victim  = r_hit ? r_hit_way : (r_emp ? r_emp_way : r_lru_way);
        age_sum = {1'b0, r_max_age} + (AGE_BITS + 1)'(r_mod ? 2'd2 : 2'd1);
        new_age = age_sum[AGE_BITS] ? '1 : age_sum[AGE_BITS-1:0];
        new_row = ram_rdata;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_IW'(w) == victim) begin
                new_row[w*WAY_W +: WAY_W] = {1'b1, r_tag, new_age};
            end
        end
    end

    // Outcome of this item and counter sums
    always_comb begin
        if (r_hit) begin
            item_hits = r_mod ? 2'd2 : 2'd1;
        end else begin
            item_hits = r_mod ? 2'd1 : 2'd0;
        end
        item_miss  = !r_hit;
        item_evict = !r_hit && !r_emp;
        hit_sum    = {1'b0, r_hit_cnt}   + (COUNT_BITS + 1)'(item_hits);
        miss_sum   = {1'b0, r_miss_cnt}  + (COUNT_BITS + 1)'(item_miss);
        evict_sum  = {1'b0, r_evict_cnt} + (COUNT_BITS + 1)'(item_evict);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_set   <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_set <= r_clr_set + 1'b1;
            end
            if (do_commit) begin
                r_hit_cnt   <= hit_sum[COUNT_BITS]   ? '1 : hit_sum[COUNT_BITS-1:0];
                r_miss_cnt  <= miss_sum[COUNT_BITS]  ? '1 : miss_sum[COUNT_BITS-1:0];
                r_evict_cnt <= evict_sum[COUNT_BITS] ? '1 : evict_sum[COUNT_BITS-1:0];
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mod <= i_q_entry[ENTRY_W-1];
            r_tag <= i_q_entry[ENTRY_W-2 -: ADDR_W];
            r_set <= i_q_entry[SET_AW-1:0];
        end
        if (do_eval) begin
            r_hit     <= e_hit;
            r_hit_way <= e_hit_way;
            r_emp     <= e_emp;
            r_emp_way <= e_emp_way;
            r_lru_way <= e_lru_way;
            r_max_age <= e_max_age;
        end
        if (do_commit) begin
            r_out_hits    <= item_hits;
            r_out_missed  <= item_miss;
            r_out_evicted <= item_evict;
        end
    end

    // Result channel; totals only move when a new result is loaded
    assign o_res.valid           = r_out_valid;
    assign o_res.hits_in_item    = r_out_hits;
    assign o_res.missed          = r_out_missed;
    assign o_res.evicted         = r_out_evicted;
    assign o_res.total_hits      = RES_CNT_W'(r_hit_cnt);
    assign o_res.total_misses    = RES_CNT_W'(r_miss_cnt);
    assign o_res.total_evictions = RES_CNT_W'(r_evict_cnt);

    // Checks
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("set RAM read and write in the same cycle");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (i_q_valid && r_state == BK_IDLE))
        else $error("queue popped outside idle or when empty");

    a_commit_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_commit |=> r_out_valid)
        else $error("committed request produced no result");

    a_hits_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_hit_cnt >= $past(r_hit_cnt)))
        else $error("hit total decreased");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CLEAR) |-> (!o_q_pop && !r_out_valid))
        else $error("request handled during clearing pass");
endmodule

// File: bench/cache_sb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the set-associative LRU tag store: a predictor of hit, miss
// and eviction outcomes plus the queue of outcomes still due. Depends on sal_pkg.
package cache_sb_pkg;
    import sal_pkg::*;

    localparam int NUM_SETS = 64;
    localparam int NUM_WAYS = 8;

    typedef struct packed {
        logic [HITS_W-1:0]    hits_in_item;
        logic                 missed;
        logic                 evicted;
        logic [RES_CNT_W-1:0] total_hits;
        logic [RES_CNT_W-1:0] total_misses;
        logic [RES_CNT_W-1:0] total_evictions;
    } t_access_outcome;

    class tag_store_scoreboard;
        // Mirror of the configuration registers
        logic [2:0] cfg_set_bits;
        logic [4:0] cfg_offset_bits;
        logic [3:0] cfg_ways;

        // Predicted tag store contents
        bit          line_valid [NUM_SETS*NUM_WAYS];
        logic [63:0] line_tag   [NUM_SETS*NUM_WAYS];
        logic [31:0] line_age   [NUM_SETS*NUM_WAYS];
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;

        t_access_outcome outcomes_due[$];
        int unsigned     mismatch_count;

        function new();
            cfg_set_bits    = RST_SET_BITS;
            cfg_offset_bits = RST_OFFSET_BITS;
            cfg_ways        = RST_WAYS;
            foreach (line_valid[i]) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_age[i]   = '0;
            end
            hit_total      = '0;
            miss_total     = '0;
            evict_total    = '0;
            mismatch_count = 0;
        endfunction

        function void set_config(logic [1:0] reg_idx, logic [31:0] value);
            case (reg_idx)
                REG_SET_BITS:    cfg_set_bits    = value[2:0];
                REG_OFFSET_BITS: cfg_offset_bits = value[4:0];
                REG_WAYS:        cfg_ways        = value[3:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] sat_inc(logic [31:0] v);
            return (v == '1) ? v : v + 32'd1;
        endfunction

        // Effective set index width and way count after clamping
        function int eff_set_bits();
            return (cfg_set_bits > 3'd6) ? 6 : int'(cfg_set_bits);
        endfunction

        function int eff_ways();
            if (cfg_ways == 4'd0) return 1;
            return (cfg_ways > 4'd8) ? 8 : int'(cfg_ways);
        endfunction

        // One lookup in the set; returns 1 on a hit, raises evicted on a replacement
        function bit probe_set(logic [63:0] addr, inout bit evicted);
            int          s, b, ways, base, hit_way, empty_way, lru_way, idx;
            bit          hit, have_empty;
            logic [63:0] tag, set_sel;
            logic [31:0] max_age, min_age, new_age;
            s          = eff_set_bits();
            b          = int'(cfg_offset_bits);
            ways       = eff_ways();
            hit        = 1'b0;
            have_empty = 1'b0;
            hit_way    = 0;
            empty_way  = 0;
            lru_way    = 0;
            max_age    = '0;
            min_age    = '0;
            tag        = addr >> (s + b);
            set_sel    = (addr >> b) & ((64'd1 << s) - 64'd1);
            base       = int'(set_sel[5:0]) * NUM_WAYS;
            // Max age covers every way in use, valid or not; lowest way wins ties
            for (int w = 0; w < ways; w++) begin
                idx = base + w;
                if (line_age[idx] > max_age) max_age = line_age[idx];
                if (w == 0 || line_age[idx] < min_age) begin
                    min_age = line_age[idx];
                    lru_way = w;
                end
                if (line_valid[idx]) begin
                    if (!hit && line_tag[idx] == tag) begin
                        hit     = 1'b1;
                        hit_way = w;
                    end
                end else if (!have_empty) begin
                    have_empty = 1'b1;
                    empty_way  = w;
                end
            end
            new_age = sat_inc(max_age);
            if (hit) begin
                line_age[base + hit_way] = new_age;
                hit_total = sat_inc(hit_total);
                return 1'b1;
            end
            miss_total = sat_inc(miss_total);
            if (have_empty) begin
                line_valid[base + empty_way] = 1'b1;
                line_tag[base + empty_way]   = tag;
                line_age[base + empty_way]   = new_age;
            end else begin
                evict_total = sat_inc(evict_total);
                line_tag[base + lru_way] = tag;
                line_age[base + lru_way] = new_age;
                evicted = 1'b1;
            end
            return 1'b0;
        endfunction

        // Accepted request: fetches are dropped, a modify looks up twice
        function void note_access(logic [OP_W-1:0] op, logic [63:0] addr);
            t_access_outcome exp;
            bit              ev;
            bit              first;
            int              hits;
            if (op == OP_FETCH) return;
            ev    = 1'b0;
            first = probe_set(addr, ev);
            hits  = first;
            if (op == OP_MODIFY) hits += probe_set(addr, ev);
            exp.hits_in_item    = hits[1:0];
            exp.missed          = !first;
            exp.evicted         = ev;
            exp.total_hits      = hit_total;
            exp.total_misses    = miss_total;
            exp.total_evictions = evict_total;
            outcomes_due.push_back(exp);
        endfunction

        function void report_field(string name, logic [31:0] exp, logic [31:0] got);
            if (exp !== got) begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
                         exp, got);
            end
        endfunction

        function void check_outcome(t_access_outcome got);
            t_access_outcome exp;
            if (outcomes_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing expected, actual %p", $realtime, got);
                return;
            end
            exp = outcomes_due.pop_front();
            report_field("hits_in_item", exp.hits_in_item, got.hits_in_item);
            report_field("missed", exp.missed, got.missed);
            report_field("evicted", exp.evicted, got.evicted);
            report_field("total_hits", exp.total_hits, got.total_hits);
            report_field("total_misses", exp.total_misses, got.total_misses);
            report_field("total_evictions", exp.total_evictions, got.total_evictions);
        endfunction

        function int outstanding();
            return outcomes_due.size();
        endfunction
    endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench of the set-associative LRU tag store: directed and random
// access requests, APB register writes, randomized stalls. Depends on sal_pkg,
// the sal_req_if / sal_res_if interfaces and cache_sb_pkg.
module tb_top;
    import sal_pkg::*;
    import cache_sb_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sal_req_if req_ch ();
    sal_res_if res_ch ();

    tag_store_scoreboard sb = new();

    int unsigned requests_accepted = 0;
    bit          src_burst         = 1'b0;
    bit          long_hold_done    = 1'b0;

    // Random-phase settings: set bits, offset bits, ways (extremes included)
    int unsigned phase_set_bits[7]    = '{0, 6, 7, 3, 2, 1, 5};
    int unsigned phase_offset_bits[7] = '{0, 16, 31, 5, 0, 12, 3};
    int unsigned phase_ways[7]        = '{1, 8, 15, 4, 0, 9, 2};

    set_assoc_lru_cache_sim DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Clock; starts low so the first rising edge already sees reset asserted
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // One request on the access channel; valid stays high for back-to-back requests
    task automatic send_access(logic [OP_W-1:0] op, logic [63:0] addr);
        int gap;
        if ($urandom_range(0, 31) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.opcode  <= op;
        req_ch.address <= addr;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        requests_accepted++;
        sb.note_access(op, addr);
    endtask

    // Stop sending and let every result still due drain
    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_config(reg_idx, value);
    endtask

    task automatic apply_config(int unsigned set_bits, int unsigned offset_bits,
                                int unsigned ways);
        drain_requests();
        write_reg(REG_SET_BITS, set_bits);
        write_reg(REG_OFFSET_BITS, offset_bits);
        write_reg(REG_WAYS, ways);
    endtask

    // Mostly addresses from a small tag/set pool so sets fill, hit and evict
    function automatic logic [63:0] pick_address();
        int          s, b, max_set;
        logic [63:0] tag, set_sel, offset;
        if ($urandom_range(0, 99) < 15) return {$urandom(), $urandom()};
        s       = sb.eff_set_bits();
        b       = int'(sb.cfg_offset_bits);
        max_set = (1 << s) - 1;
        tag     = 64'($urandom_range(0, 2 * sb.eff_ways() + 2));
        if ($urandom_range(0, 7) == 0) tag = {$urandom(), $urandom()};
        set_sel = 64'($urandom_range(0, (max_set < 3) ? max_set : 3));
        offset  = {$urandom(), $urandom()} & ((64'd1 << b) - 64'd1);
        return (tag << (s + b)) | (set_sel << b) | offset;
    endfunction

    task automatic run_random(int unsigned data_items);
        int unsigned      sent;
        logic [OP_W-1:0]  op;
        sent = 0;
        while (sent < data_items) begin
            op = ($urandom_range(0, 99) < 10) ? OP_FETCH : OP_W'($urandom_range(1, 3));
            send_access(op, pick_address());
            if (op != OP_FETCH) sent++;
        end
    endtask

    // Result side: random stalls, one long hold-off so the input backs up
    initial begin
        int stall;
        bit sink_burst;
        t_access_outcome got;
        sink_burst    = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 13);
            if (!long_hold_done && requests_accepted >= 250) begin
                stall          = 80;
                long_hold_done = 1'b1;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (res_ch.valid !== 1'b1) @(posedge i_clk);
            got.hits_in_item    = res_ch.hits_in_item;
            got.missed          = res_ch.missed;
            got.evicted         = res_ch.evicted;
            got.total_hits      = res_ch.total_hits;
            got.total_misses    = res_ch.total_misses;
            got.total_evictions = res_ch.total_evictions;
            sb.check_outcome(got);
        end
    end

    // Main sequence
    initial begin
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.opcode  <= OP_FETCH;
        req_ch.address <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass holds ready low
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);

        // Directed: reset settings, one way
        send_access(OP_LOAD, 64'h0);
        send_access(OP_LOAD, 64'h0);
        send_access(OP_STORE, '1);
        send_access(OP_MODIFY, 64'h1000);
        send_access(OP_MODIFY, 64'h1000);
        send_access(OP_FETCH, 64'h1234_5678);
        send_access(OP_LOAD, 64'h8);

        // Same tag left in two ways: shrink to one way, refill, widen again
        apply_config(4, 4, 2);
        send_access(OP_LOAD, 64'h100);
        send_access(OP_LOAD, 64'h0);
        apply_config(4, 4, 1);
        send_access(OP_LOAD, 64'h100);
        apply_config(4, 4, 2);
        send_access(OP_LOAD, 64'h100);
        send_access(OP_MODIFY, 64'h100);

        // Oversized set bits and offset, full ways
        apply_config(7, 31, 8);
        send_access(OP_LOAD, '1);
        send_access(OP_LOAD, 64'h0);
        send_access(OP_STORE, 64'h8000_0000_0000_0000);
        send_access(OP_MODIFY, '1);
        send_access(OP_FETCH, '1);

        // Random phases
        foreach (phase_ways[p]) begin
            apply_config(phase_set_bits[p], phase_offset_bits[p], phase_ways[p]);
            run_random(108);
        end

        drain_requests();
        repeat (20) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
